// ===== hdl/xy_model_metropolis_update_core_defines.svh =====
// Assertion macros for the XY Metropolis update core
`ifndef XY_MODEL_METROPOLIS_UPDATE_CORE_DEFINES_SVH
`define XY_MODEL_METROPOLIS_UPDATE_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define XYMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XYMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/xymm_pkg.sv =====
`default_nettype none
package xymm_pkg;

    localparam int LATTICE_SIDE = 32;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_TRIAL = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic CFG_STEP_HALF_WIDTH = 1'b0;
    localparam logic CFG_INV_TEMP        = 1'b1;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [28:0] EXP_M1_Q30  = 29'd395007542;

    localparam logic [3:0] COS_LAST_TERM = 4'd3;
    localparam logic [3:0] EXP_LAST_TERM = 4'd8;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  site_x;
        logic [4:0]  site_y;
        logic [15:0] angle_value;
        logic [15:0] step_draw;
        logic [15:0] accept_draw;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [15:0] site_angle;
        logic [15:0] accept_count;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_WRAP, S_LOAD, S_READ, S_READ_LAST, S_DELTA, S_NEW,
        C_SETUP, C_M1, C_X, C_M2, C_X2,
        S_SER_MUL, S_SER_DIVS, S_SER_DIVW,
        C_ACC, E_CHK, E_MUL, E_SPLIT, E_KCHK, E_KMUL, E_KSHIFT, E_FIN,
        S_COMMIT, S_DONE
    } t_state;

    // divisor of each nested Taylor step: cosine 56,30,12,2; exp 9 down to 1
    function automatic logic [5:0] series_div(input logic exp_mode, input logic [3:0] term);
        logic [5:0] d;
        if (exp_mode) begin
            d = 6'd9 - {2'b0, term};
        end else begin
            case (term)
                4'd0:    d = 6'd56;
                4'd1:    d = 6'd30;
                4'd2:    d = 6'd12;
                default: d = 6'd2;
            endcase
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/xymm_ram.sv =====
`default_nettype none
module xymm_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/xymm_cdiv.sv =====
`default_nettype none
`include "xy_model_metropolis_update_core_defines.svh"
module xymm_cdiv
    import xymm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [5:0]  i_divisor,
    output logic             o_done,
    output logic      [31:0] o_quot
);
    logic        r_busy;
    logic [2:0]  r_cnt;
    logic [5:0]  r_rem;
    logic [5:0]  r_dvs;
    logic [31:0] r_dvd;
    logic [5:0]  w_rem;
    logic [31:0] w_dvd;
    logic [6:0]  w_trial;

    // four restoring steps per cycle
    always_comb begin
        w_rem = r_rem;
        w_dvd = r_dvd;
        w_trial = '0;
        for (int i = 0; i < 4; i++) begin
            w_trial = {w_rem, w_dvd[31]};
            if (w_trial >= {1'b0, r_dvs}) begin
                w_trial = w_trial - {1'b0, r_dvs};
                w_dvd = {w_dvd[30:0], 1'b1};
            end else begin
                w_dvd = {w_dvd[30:0], 1'b0};
            end
            w_rem = w_trial[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == 3'd7);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= w_dvd;
            r_rem <= w_rem;
        end
    end

    assign o_quot = r_dvd;

    `XYMM_ASSERT_IMP(a_start_idle, i_start, !r_busy, "divider started while busy")
    `XYMM_ASSERT_IMP(a_done_idle, o_done, !r_busy && !i_start, "done pulse overlaps work")
endmodule
`default_nettype wire

// ===== hdl/xy_model_metropolis_update_core.sv =====
// XY-model Metropolis update core.
// Input channel (i_in_valid / o_in_stall, payload i_in_item) takes one beat per
// command: load a site angle, run one Metropolis trial, or clear the acceptance
// counter. Each beat gives exactly one output beat (o_out_valid / i_out_stall,
// payload o_out_item) with the accept flag, the site angle after the command
// and the acceptance count.
// Registers are written over i_cfg_valid / o_cfg_ready: index 0 step half
// width, index 1 inverse temperature (Q4.12). o_cfg_ready is always high.
// One command at a time: o_in_stall is high from acceptance until the result
// sits in the output register. Coordinates are reduced one subtraction a cycle.
// A trial makes five lattice reads, eight cosines through one shared multiplier
// and a radix-16 constant divider (four nested steps per cosine), then an exp
// series of nine steps and up to fifteen e^-1 products.
// Reset clears the counter and sets the registers to defaults; lattice sites
// read undefined until loaded. A stalled output beat holds; the next command is
// taken while it waits.
`default_nettype none
`include "xy_model_metropolis_update_core_defines.svh"
module xy_model_metropolis_update_core
    import xymm_pkg::*;
#(
    parameter int LatticeSide = LATTICE_SIDE
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int CW        = $clog2(LatticeSide);
    localparam int SiteCount = LatticeSide * LatticeSide;
    localparam int AW        = $clog2(SiteCount);

    t_state r_state, n_state;
    t_in_item r_item;
    logic [14:0] r_shw;
    logic [15:0] r_beta;
    logic [15:0] r_cnt;
    logic [4:0]  r_wx, r_wy;
    logic [2:0]  r_k;
    logic [15:0] r_old, r_new;
    logic [15:0] r_nb [4];
    logic [14:0] r_rr;
    logic        r_neg;
    logic [30:0] r_x;
    logic [31:0] r_ser_a;
    logic [30:0] r_t;
    logic [3:0]  r_term;
    logic        r_exp;
    logic [3:0]  r_ek;
    logic signed [18:0] r_de;
    logic        r_acc;
    logic [15:0] r_res_angle;
    logic signed [65:0] r_prod;

    logic signed [32:0] w_ma, w_mb;
    logic        w_ram_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [15:0] w_wdata, w_rdata;
    logic        w_div_start, w_div_done;
    logic [31:0] w_quot;
    logic [CW-1:0] w_cx, w_cy, w_xp, w_xm, w_yp, w_ym;
    logic        w_wrapped;
    logic        w_trial;
    logic        w_last_term;
    logic        w_out_free;
    logic [15:0] w_phase;
    logic signed [17:0] w_step;
    logic [30:0] w_rsum;
    logic [14:0] w_cosv;
    logic signed [18:0] w_cs;
    logic [16:0] w_e;

    function automatic logic [AW-1:0] site_idx(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return AW'(AW'(y) * AW'(LatticeSide)) + AW'(x);
    endfunction

    assign w_cx = CW'(r_wx);
    assign w_cy = CW'(r_wy);
    assign w_xp = (w_cx == CW'(LatticeSide - 1)) ? '0 : w_cx + 1'b1;
    assign w_xm = (w_cx == '0) ? CW'(LatticeSide - 1) : w_cx - 1'b1;
    assign w_yp = (w_cy == CW'(LatticeSide - 1)) ? '0 : w_cy + 1'b1;
    assign w_ym = (w_cy == '0) ? CW'(LatticeSide - 1) : w_cy - 1'b1;
    assign w_wrapped = (9'(r_wx) < 9'(LatticeSide)) && (9'(r_wy) < 9'(LatticeSide));
    assign w_trial = (r_item.func == FUNC_TRIAL);
    assign w_last_term = (r_term == (r_exp ? EXP_LAST_TERM : COS_LAST_TERM));
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_phase = (r_k[0] ? r_new : r_old) - r_nb[r_k[2:1]];
    assign w_step = $signed({1'b0, r_item.step_draw, 1'b0}) - 18'sd65535;
    assign w_rsum = r_t + 31'd32768;
    assign w_cosv = w_rsum[30:16];
    assign w_cs = $signed({4'b0, w_cosv});
    assign w_e = 17'((r_t + 31'd8192) >> 14);

    xymm_ram #(.Width(16), .Depth(SiteCount)) u_lattice (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    xymm_cdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod[61:30]),
        .i_divisor  (series_div(r_exp, r_term)),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_WRAP;
            S_WRAP:      if (w_wrapped) n_state = (r_item.func == FUNC_LOAD) ? S_LOAD : S_READ;
            S_LOAD:      n_state = S_DONE;
            S_READ:      if (!w_trial || r_k == 3'd4) n_state = S_READ_LAST;
            S_READ_LAST: n_state = w_trial ? S_DELTA : S_DONE;
            S_DELTA:     n_state = S_NEW;
            S_NEW:       n_state = C_SETUP;
            C_SETUP:     n_state = C_M1;
            C_M1:        n_state = C_X;
            C_X:         n_state = C_M2;
            C_M2:        n_state = C_X2;
            C_X2:        n_state = S_SER_MUL;
            S_SER_MUL:   n_state = S_SER_DIVS;
            S_SER_DIVS:  n_state = S_SER_DIVW;
            S_SER_DIVW: begin
                if (w_div_done) begin
                    if (!w_last_term) n_state = S_SER_MUL;
                    else n_state = r_exp ? E_KCHK : C_ACC;
                end
            end
            C_ACC:       n_state = (r_k == 3'd7) ? E_CHK : C_SETUP;
            E_CHK:       n_state = r_de[18] ? S_COMMIT : E_MUL;
            E_MUL:       n_state = E_SPLIT;
            E_SPLIT:     n_state = (r_prod[33:30] != 4'd0) ? S_COMMIT : S_SER_MUL;
            E_KCHK:      n_state = (r_ek == 4'd0) ? E_FIN : E_KMUL;
            E_KMUL:      n_state = E_KSHIFT;
            E_KSHIFT:    n_state = E_KCHK;
            E_FIN:       n_state = S_COMMIT;
            S_COMMIT:    n_state = S_DONE;
            S_DONE:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_ram_we = 1'b0;
        w_waddr = site_idx(w_cx, w_cy);
        w_wdata = r_new;
        w_raddr = site_idx(w_cx, w_cy);
        w_div_start = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                w_ram_we = 1'b1;
                w_wdata = r_item.angle_value;
            end
            S_READ: begin
                case (r_k)
                    3'd1:    w_raddr = site_idx(w_xp, w_cy);
                    3'd2:    w_raddr = site_idx(w_xm, w_cy);
                    3'd3:    w_raddr = site_idx(w_cx, w_yp);
                    3'd4:    w_raddr = site_idx(w_cx, w_ym);
                    default: w_raddr = site_idx(w_cx, w_cy);
                endcase
            end
            S_DELTA: begin
                w_ma = 33'(w_step);
                w_mb = $signed({18'b0, r_shw});
            end
            C_M1: begin
                w_ma = $signed({18'b0, r_rr});
                w_mb = $signed({2'b0, HALF_PI_Q30});
            end
            C_M2: begin
                w_ma = $signed({2'b0, r_x});
                w_mb = $signed({2'b0, r_x});
            end
            S_SER_MUL: begin
                w_ma = $signed({1'b0, r_ser_a});
                w_mb = $signed({2'b0, r_t});
            end
            S_SER_DIVS: w_div_start = 1'b1;
            E_MUL: begin
                w_ma = $signed({17'b0, r_beta});
                w_mb = $signed({15'b0, r_de[17:0]});
            end
            E_KMUL: begin
                w_ma = $signed({2'b0, r_t});
                w_mb = $signed({4'b0, EXP_M1_Q30});
            end
            S_COMMIT: w_ram_we = r_acc;
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shw       <= 15'd8192;
            r_beta      <= 16'd4096;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEP_HALF_WIDTH: r_shw  <= i_cfg_data[14:0];
                    CFG_INV_TEMP:        r_beta <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_READ_LAST && r_item.func == FUNC_CLEAR) begin
                r_cnt <= '0;
            end
            if (r_state == S_COMMIT && r_acc && r_cnt != 16'hFFFF) begin
                r_cnt <= r_cnt + 16'd1;
            end
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            S_IDLE: begin
                r_item <= i_in_item;
                r_wx   <= i_in_item.site_x;
                r_wy   <= i_in_item.site_y;
                r_k    <= '0;
            end
            S_WRAP: begin
                if (9'(r_wx) >= 9'(LatticeSide)) r_wx <= r_wx - 5'(LatticeSide);
                if (9'(r_wy) >= 9'(LatticeSide)) r_wy <= r_wy - 5'(LatticeSide);
            end
            S_LOAD: begin
                r_res_angle <= r_item.angle_value;
                r_acc       <= 1'b1;
            end
            S_READ: begin
                r_k <= r_k + 3'd1;
                if (r_k == 3'd1) r_old <= w_rdata;
                else if (r_k != 3'd0) r_nb[2'(r_k - 3'd2)] <= w_rdata;
            end
            S_READ_LAST: begin
                if (w_trial) begin
                    r_nb[3] <= w_rdata;
                end else begin
                    r_old       <= w_rdata;
                    r_res_angle <= w_rdata;
                    r_acc       <= 1'b0;
                end
            end
            S_NEW: begin
                r_new <= r_old + r_prod[31:16];
                r_k   <= '0;
                r_de  <= '0;
            end
            C_SETUP: begin
                r_rr  <= w_phase[14] ? 15'd16384 - {1'b0, w_phase[13:0]}
                                     : {1'b0, w_phase[13:0]};
                r_neg <= w_phase[15] ^ w_phase[14];
            end
            C_X: r_x <= r_prod[44:14];
            C_X2: begin
                r_ser_a <= r_prod[61:30];
                r_t     <= Q30_ONE;
                r_term  <= '0;
                r_exp   <= 1'b0;
            end
            S_SER_DIVW: begin
                if (w_div_done) begin
                    r_t    <= (w_quot > 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - w_quot);
                    r_term <= r_term + 4'd1;
                end
            end
            C_ACC: begin
                r_de <= (r_neg ^ r_k[0]) ? r_de - w_cs : r_de + w_cs;
                r_k  <= r_k + 3'd1;
            end
            E_CHK: r_acc <= r_de[18];
            E_SPLIT: begin
                r_acc   <= 1'b0;
                r_ek    <= r_prod[29:26];
                r_ser_a <= {2'b0, r_prod[25:10], 14'b0};
                r_t     <= Q30_ONE;
                r_term  <= '0;
                r_exp   <= 1'b1;
            end
            E_KSHIFT: begin
                r_t  <= r_prod[60:30];
                r_ek <= r_ek - 4'd1;
            end
            E_FIN: r_acc <= (w_e > {1'b0, r_item.accept_draw});
            S_COMMIT: r_res_angle <= r_acc ? r_new : r_old;
            S_DONE: if (w_out_free) o_out_item <= '{r_acc, r_res_angle, r_cnt};
            default: ;
        endcase
    end

    `XYMM_ASSERT_IMP(a_cnt_step, r_cnt != $past(r_cnt), r_cnt == '0 || r_cnt == $past(r_cnt) + 16'd1, "counter jumped")
    `XYMM_ASSERT_IMP(a_out_load, $rose(o_out_valid), $past(r_state) == S_DONE, "beat not from done")
    `XYMM_ASSERT_IMP(a_ram_we, w_ram_we, r_state == S_LOAD || r_state == S_COMMIT, "stray lattice write")
    `XYMM_ASSERT_NXT(a_busy, i_in_valid && !o_in_stall, r_state == S_WRAP, "accepted beat lost")
endmodule
`default_nettype wire
